// File: rtl/krrt_pkg.sv
// Shared types, codes and helpers for the keyed ring record table.
// No dependencies.
package krrt_pkg;

    localparam logic [2:0] KIND_UPSERT  = 3'd0;
    localparam logic [2:0] KIND_REMOVE  = 3'd1;
    localparam logic [2:0] KIND_RESOLVE = 3'd2;
    localparam logic [2:0] KIND_FIND    = 3'd3;
    localparam logic [2:0] KIND_AT      = 3'd4;
    localparam logic [2:0] KIND_CLEAR   = 3'd5;
    localparam logic [2:0] KIND_SUMMARY = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic [2:0] SUM_LAST = 3'd5;

    typedef struct packed {
        logic [63:0] key;
        logic [2:0]  severity;
        logic [2:0]  category;
        logic        resolved;
        logic [31:0] payload;
        logic [31:0] sequence_no;
        logic [31:0] revision;
    } t_rec;

    typedef struct packed {
        logic load;
        logic take_new;
    } t_cell_ctl;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// File: rtl/krrt_cell.sv
// One record cell of the chain: loads from its neighbor or a new record.
// Depends on krrt_pkg.
module krrt_cell
    import krrt_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_rec      i_nbr,
    input  t_rec      i_new,
    output t_rec      o_rec
);

    t_rec r_rec;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rec <= i_ctl.take_new ? i_new : i_nbr;
        end
    end

    assign o_rec = r_rec;

endmodule

// File: rtl/keyed_ring_record_table_top.sv
// Top level of the keyed ring record table: control, counters and the cell chain.
// Depends on krrt_pkg and krrt_cell.
//
// channel  | handshake            | payload
// ---------+----------------------+-----------------------------------------
// command  | i_start / o_busy     | i_kind i_key i_severity i_category ...
// result   | o_valid (strobe)     | o_status o_found_* o_stat_value o_last
// config   | i_cfg_we             | i_cfg_wdata (capacity_in_use)
//
// For each item the chain first rotates once through all DEPTH cells so
// each record passes the head comparator, then S_APPLY updates the ring.
// Summary then passes through S_EMIT and emits its six results on consecutive cycles.
// Reset empties the ring at once; no clearing pass. Results are one-cycle
// strobes; the receiver cannot stall them.
module keyed_ring_record_table_top
    import krrt_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_kind,
    input  logic [63:0] i_key,
    input  logic [2:0]  i_severity,
    input  logic [2:0]  i_category,
    input  logic        i_resolved_flag,
    input  logic [31:0] i_payload,
    input  logic [5:0]  i_position,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [63:0] o_found_key,
    output logic [2:0]  o_found_severity,
    output logic [2:0]  o_found_category,
    output logic        o_found_resolved,
    output logic [31:0] o_found_payload,
    output logic [31:0] o_found_sequence,
    output logic [31:0] o_found_revision,
    output logic [31:0] o_stat_value,
    output logic        o_last
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int CAP_RST = (DEPTH < 64) ? DEPTH : 64;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_EMIT} t_state;

    t_state      r_state;
    logic [IW-1:0] r_step;
    logic [IW-1:0] r_m;
    logic [2:0]  r_kind;
    logic [63:0] r_key;
    logic [2:0]  r_sev;
    logic [2:0]  r_cat;
    logic        r_resf;
    logic [31:0] r_pay;
    logic [5:0]  r_pos;
    logic        r_hit;
    t_rec        r_found;
    logic [CW-1:0] r_rcnt;
    logic [CW-1:0] r_held;
    logic [CW-1:0] r_cap;
    logic [31:0] r_serial;
    logic [31:0] r_recv;
    logic [31:0] r_ovw;
    logic [31:0] r_trev;
    logic [2:0]  r_eidx;
    logic        r_valid;
    logic [1:0]  r_status;
    t_rec        r_orec;
    logic [31:0] r_stat;
    logic        r_last;

    t_rec      w_cell [DEPTH];
    t_cell_ctl w_ctl  [DEPTH];
    t_rec      w_head;
    t_rec      w_tail;
    t_rec      w_new;
    logic        w_valid_t;
    logic        w_keyhit;
    logic        w_hit;
    logic        w_keyok;
    logic        w_modify;
    logic [31:0] w_rev_inc;
    logic        w_app;
    logic        w_ovw;
    logic        w_rem;
    logic [31:0] w_cfg;
    logic [31:0] w_cap_c;
    logic [31:0] w_held32;

    assign w_head    = w_cell[0];
    assign w_held32  = 32'(r_held);
    assign w_rev_inc = sat_inc(r_trev);
    assign w_keyok   = (r_key != 64'd0);
    assign w_valid_t = 32'(r_step) < w_held32;
    assign w_keyhit  = w_valid_t && (w_head.key == r_key) && !r_hit;
    assign w_hit     = (r_kind == KIND_AT)
                     ? (w_valid_t && (32'(r_step) == 32'(r_pos)))
                     : w_keyhit;

    // rewrite the record as it leaves the head
    assign w_modify = (r_state == S_SCAN) && w_keyhit && w_keyok
                   && ((r_kind == KIND_UPSERT) || (r_kind == KIND_RESOLVE));

    always_comb begin
        w_tail = w_head;
        if (w_modify) begin
            w_tail.revision = w_rev_inc;
            if (r_kind == KIND_UPSERT) begin
                w_tail.severity = r_sev;
                w_tail.category = r_cat;
                w_tail.payload  = r_pay;
            end
            w_tail.resolved = r_resf;
        end
    end

    always_comb begin
        w_new.key         = r_key;
        w_new.severity    = r_sev;
        w_new.category    = r_cat;
        w_new.resolved    = r_resf;
        w_new.payload     = r_pay;
        w_new.sequence_no = r_serial;
        w_new.revision    = w_rev_inc;
    end

    assign w_app = (r_state == S_APPLY) && (r_kind == KIND_UPSERT) && w_keyok && !r_hit
                && (r_held < r_cap);
    assign w_ovw = (r_state == S_APPLY) && (r_kind == KIND_UPSERT) && w_keyok && !r_hit
                && (r_held >= r_cap);
    assign w_rem = (r_state == S_APPLY) && (r_kind == KIND_REMOVE) && w_keyok && r_hit;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_chain
        t_rec w_nbr;
        if (gi == DEPTH - 1) begin : g_tail
            assign w_nbr = w_tail;
        end else begin : g_mid
            assign w_nbr = w_cell[gi + 1];
        end

        always_comb begin
            w_ctl[gi] = '0;
            if (r_state == S_SCAN) begin
                w_ctl[gi].load = 1'b1;
            end else if (w_app && (gi == w_held32)) begin
                w_ctl[gi] = '{load: 1'b1, take_new: 1'b1};
            end else if (w_ovw && (gi == w_held32 - 32'd1)) begin
                w_ctl[gi] = '{load: 1'b1, take_new: 1'b1};
            end else if (w_ovw && (gi < w_held32 - 32'd1)) begin
                w_ctl[gi].load = 1'b1;
            end else if (w_rem && (gi >= 32'(r_m)) && (gi < w_held32 - 32'd1)) begin
                w_ctl[gi].load = 1'b1;
            end
        end

        krrt_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (w_ctl[gi]),
            .i_nbr (w_nbr),
            .i_new (w_new),
            .o_rec (w_cell[gi])
        );
    end

    assign w_cfg   = 32'(i_cfg_wdata);
    assign w_cap_c = (w_cfg == 32'd0) ? 32'd1 : ((w_cfg > DEPTH) ? DEPTH : w_cfg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_hit    <= 1'b0;
            r_rcnt   <= '0;
            r_held   <= '0;
            r_cap    <= CW'(CAP_RST);
            r_serial <= 32'd1;
            r_recv   <= '0;
            r_ovw    <= '0;
            r_trev   <= '0;
            r_eidx   <= '0;
            r_valid  <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_cap  <= CW'(w_cap_c);
                r_held <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_kind  <= i_kind;
                        r_key   <= i_key;
                        r_sev   <= i_severity;
                        r_cat   <= i_category;
                        r_resf  <= i_resolved_flag;
                        r_pay   <= i_payload;
                        r_pos   <= i_position;
                        r_step  <= '0;
                        r_hit   <= 1'b0;
                        r_rcnt  <= '0;
                        r_found <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_hit   <= 1'b1;
                        r_m     <= r_step;
                        r_found <= w_head;
                    end
                    if (w_valid_t && w_head.resolved) begin
                        r_rcnt <= r_rcnt + CW'(1);
                    end
                    r_step <= r_step + IW'(1);
                    if (32'(r_step) == DEPTH - 1) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_orec   <= '0;
                    r_stat   <= '0;
                    r_status <= ST_OK;
                    r_last   <= 1'b1;
                    r_valid  <= 1'b1;
                    r_state  <= S_IDLE;
                    case (r_kind)
                        KIND_UPSERT: begin
                            if (!w_keyok) begin
                                r_status <= ST_INVALID;
                            end else begin
                                r_recv <= sat_inc(r_recv);
                                r_trev <= w_rev_inc;
                                if (!r_hit) begin
                                    r_serial <= sat_inc(r_serial);
                                    if (w_app) begin
                                        r_held <= r_held + CW'(1);
                                    end else begin
                                        r_ovw <= sat_inc(r_ovw);
                                    end
                                end
                            end
                        end
                        KIND_REMOVE, KIND_RESOLVE: begin
                            if (!w_keyok) begin
                                r_status <= ST_INVALID;
                            end else if (!r_hit) begin
                                r_status <= ST_NOTFOUND;
                            end else begin
                                r_trev <= w_rev_inc;
                                if (r_kind == KIND_REMOVE) begin
                                    r_held <= r_held - CW'(1);
                                end
                            end
                        end
                        KIND_FIND, KIND_AT: begin
                            if (r_hit) begin
                                r_orec <= r_found;
                            end else begin
                                r_status <= ST_NOTFOUND;
                            end
                        end
                        KIND_CLEAR: begin
                            r_held <= '0;
                            r_trev <= w_rev_inc;
                        end
                        KIND_SUMMARY: begin
                            r_valid <= 1'b0;
                            r_eidx  <= '0;
                            r_state <= S_EMIT;
                        end
                        default: begin
                            r_status <= ST_INVALID;
                        end
                    endcase
                end
                S_EMIT: begin
                    r_valid  <= 1'b1;
                    r_status <= ST_OK;
                    r_orec   <= '0;
                    r_last   <= (r_eidx == SUM_LAST);
                    case (r_eidx)
                        3'd0:    r_stat <= w_held32;
                        3'd1:    r_stat <= r_recv;
                        3'd2:    r_stat <= r_ovw;
                        3'd3:    r_stat <= r_trev;
                        3'd4:    r_stat <= 32'(r_rcnt);
                        default: r_stat <= 32'(r_held - r_rcnt);
                    endcase
                    r_eidx <= r_eidx + 3'd1;
                    if (r_eidx == SUM_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_found_key      = r_orec.key;
    assign o_found_severity = r_orec.severity;
    assign o_found_category = r_orec.category;
    assign o_found_resolved = r_orec.resolved;
    assign o_found_payload  = r_orec.payload;
    assign o_found_sequence = r_orec.sequence_no;
    assign o_found_revision = r_orec.revision;
    assign o_stat_value     = r_stat;
    assign o_last           = r_last;

`ifndef ASSERT_OFF
    a_held_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= r_cap) else $error("held count exceeds capacity");
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> o_last) else $error("error result not last");
    a_summary_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid) else $error("summary results broken up");
`endif

endmodule

// File: test/tb_top.sv
// Self-checking testbench for keyed_ring_record_table_top.
// Depends on krrt_pkg and the table RTL; predicts every result in-line and checks each strobe.
`timescale 1ns / 1ps

module tb_top;
    import krrt_pkg::*;

    localparam int DEPTH    = 64;
    localparam int WD_LIMIT = 4000;

    localparam logic [2:0] KIND_UNKNOWN = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] key;
        logic [2:0]  severity;
        logic [2:0]  category;
        logic        resolved;
        logic [31:0] payload;
        logic [31:0] seq_no;
        logic [31:0] revision;
        logic [31:0] stat;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [2:0]  i_kind = '0;
    logic [63:0] i_key = '0;
    logic [2:0]  i_severity = '0;
    logic [2:0]  i_category = '0;
    logic        i_resolved_flag = 1'b0;
    logic [31:0] i_payload = '0;
    logic [5:0]  i_position = '0;
    logic        i_cfg_we = 1'b0;
    logic [6:0]  i_cfg_wdata = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [63:0] o_found_key;
    logic [2:0]  o_found_severity;
    logic [2:0]  o_found_category;
    logic        o_found_resolved;
    logic [31:0] o_found_payload;
    logic [31:0] o_found_sequence;
    logic [31:0] o_found_revision;
    logic [31:0] o_stat_value;
    logic        o_last;

    keyed_ring_record_table_top #(.DEPTH(DEPTH)) DUT (.*);

    always #10 i_clk = ~i_clk;

    // predicted table contents
    logic [63:0] ring_key [DEPTH];
    logic [2:0]  ring_sev [DEPTH];
    logic [2:0]  ring_cat [DEPTH];
    logic        ring_res [DEPTH];
    logic [31:0] ring_pay [DEPTH];
    logic [31:0] ring_seq [DEPTH];
    logic [31:0] ring_rev [DEPTH];
    int          oldest, held, capacity;
    logic [31:0] serial, received, overwrites, revision;

    t_result     pending_results[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          idling_on = 1'b1;
    bit          timed_out = 1'b0;
    logic [63:0] used_keys[$];

    function automatic int slot_at(int logical);
        return (oldest + logical) % capacity;
    endfunction

    function automatic int search_key(logic [63:0] k);
        for (int i = 0; i < held; i++)
            if (ring_key[slot_at(i)] == k) return i;
        return -1;
    endfunction

    function automatic t_result plain_result(logic [1:0] st, logic [31:0] sv, logic lst);
        t_result r;
        r = '{default: '0};
        r.status = st;
        r.stat = sv;
        r.last = lst;
        return r;
    endfunction

    function automatic t_result record_result(int s);
        t_result r;
        r = '{default: '0};
        r.status = ST_OK;
        r.key = ring_key[s];
        r.severity = ring_sev[s];
        r.category = ring_cat[s];
        r.resolved = ring_res[s];
        r.payload = ring_pay[s];
        r.seq_no = ring_seq[s];
        r.revision = ring_rev[s];
        r.last = 1'b1;
        return r;
    endfunction

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void predict_item(logic [2:0] kind, logic [63:0] k, logic [2:0] sev,
                                         logic [2:0] cat, logic rf, logic [31:0] pay,
                                         logic [5:0] pos);
        int lg, dst, s;
        logic [31:0] sq, nres, nact;
        lg = search_key(k);
        case (kind)
            KIND_UPSERT: begin
                if (k == 0) begin
                    pending_results.push_back(plain_result(ST_INVALID, 0, 1));
                    return;
                end
                received = bump(received);
                revision = bump(revision);
                if (lg >= 0) begin
                    dst = slot_at(lg);
                    sq = ring_seq[dst];
                end else begin
                    sq = serial;
                    serial = bump(serial);
                    if (held < capacity) begin
                        dst = slot_at(held);
                        held++;
                    end else begin
                        dst = oldest;
                        oldest = (oldest + 1) % capacity;
                        overwrites = bump(overwrites);
                    end
                end
                ring_key[dst] = k; ring_sev[dst] = sev; ring_cat[dst] = cat;
                ring_res[dst] = rf; ring_pay[dst] = pay; ring_seq[dst] = sq;
                ring_rev[dst] = revision;
                pending_results.push_back(plain_result(ST_OK, 0, 1));
            end
            KIND_REMOVE, KIND_RESOLVE: begin
                if (k == 0) pending_results.push_back(plain_result(ST_INVALID, 0, 1));
                else if (lg < 0) pending_results.push_back(plain_result(ST_NOTFOUND, 0, 1));
                else begin
                    if (kind == KIND_REMOVE) begin
                        for (int i = lg; i + 1 < held; i++) begin
                            dst = slot_at(i); s = slot_at(i + 1);
                            ring_key[dst] = ring_key[s]; ring_sev[dst] = ring_sev[s];
                            ring_cat[dst] = ring_cat[s]; ring_res[dst] = ring_res[s];
                            ring_pay[dst] = ring_pay[s]; ring_seq[dst] = ring_seq[s];
                            ring_rev[dst] = ring_rev[s];
                        end
                        held--;
                        revision = bump(revision);
                    end else begin
                        s = slot_at(lg);
                        ring_res[s] = rf;
                        revision = bump(revision);
                        ring_rev[s] = revision;
                    end
                    pending_results.push_back(plain_result(ST_OK, 0, 1));
                end
            end
            KIND_FIND:
                if (lg < 0) pending_results.push_back(plain_result(ST_NOTFOUND, 0, 1));
                else pending_results.push_back(record_result(slot_at(lg)));
            KIND_AT:
                if (pos >= held) pending_results.push_back(plain_result(ST_NOTFOUND, 0, 1));
                else pending_results.push_back(record_result(slot_at(pos)));
            KIND_CLEAR: begin
                held = 0; oldest = 0;
                revision = bump(revision);
                pending_results.push_back(plain_result(ST_OK, 0, 1));
            end
            KIND_SUMMARY: begin
                nres = 0; nact = 0;
                for (int i = 0; i < held; i++)
                    if (ring_res[slot_at(i)]) nres = bump(nres); else nact = bump(nact);
                pending_results.push_back(plain_result(ST_OK, held, 0));
                pending_results.push_back(plain_result(ST_OK, received, 0));
                pending_results.push_back(plain_result(ST_OK, overwrites, 0));
                pending_results.push_back(plain_result(ST_OK, revision, 0));
                pending_results.push_back(plain_result(ST_OK, nres, 0));
                pending_results.push_back(plain_result(ST_OK, nact, 1));
            end
            default: pending_results.push_back(plain_result(ST_INVALID, 0, 1));
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_result exp_r, got;
        if (i_rst_n && o_valid) begin
            results_seen++;
            got = '{o_status, o_found_key, o_found_severity, o_found_category,
                    o_found_resolved, o_found_payload, o_found_sequence,
                    o_found_revision, o_stat_value, o_last};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %p", got);
            end else begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
                end
            end
        end
    end

    // watchdog: cycles without any accepted item or result
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic random_gap();
        if (idling_on && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
    endtask

    task automatic send_item(logic [2:0] kind, logic [63:0] k, logic [2:0] sev = 0,
                             logic [2:0] cat = 0, logic rf = 0, logic [31:0] pay = 0,
                             logic [5:0] pos = 0);
        random_gap();
        @(negedge i_clk);
        i_kind <= kind; i_key <= k; i_severity <= sev; i_category <= cat;
        i_resolved_flag <= rf; i_payload <= pay; i_position <= pos;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_item(kind, k, sev, cat, rf, pay, pos);
        items_sent++;
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DEPTH + 10) @(negedge i_clk);
    endtask

    // write capacity while idle; the ring empties and the counters stay
    task automatic set_capacity(logic [6:0] value);
        drain();
        i_cfg_wdata <= value;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        capacity = (value < 1) ? 1 : (value > DEPTH) ? DEPTH : value;
        oldest = 0;
        held = 0;
    endtask

    function automatic logic [63:0] pick_key();
        if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed();
        send_item(KIND_SUMMARY, 0);
        send_item(KIND_UPSERT, 0, 7, 7, 1, '1);                 // empty id rejected
        send_item(KIND_REMOVE, 0);
        send_item(KIND_RESOLVE, 0, 0, 0, 1);
        send_item(KIND_FIND, 0);
        send_item(KIND_AT, 0, 0, 0, 0, 0, 0);                   // empty ring
        send_item(KIND_UPSERT, '1, 7, 7, 1, '1);
        send_item(KIND_UPSERT, 64'h1, 0, 0, 0, 0);
        send_item(KIND_UPSERT, 64'h8000_0000_0000_0000, 5, 2, 0, 32'hA5A5_5A5A);
        send_item(KIND_UPSERT, 64'h1, 3, 4, 1, 32'h1234_5678);  // replace keeps sequence
        send_item(KIND_FIND, 64'h1);
        send_item(KIND_FIND, 64'h77);                           // missing key
        send_item(KIND_AT, 0, 0, 0, 0, 0, 2);
        send_item(KIND_AT, 0, 0, 0, 0, 0, 63);                  // out of range
        send_item(KIND_RESOLVE, '1, 0, 0, 0);
        send_item(KIND_RESOLVE, 64'h55, 0, 0, 1);
        send_item(KIND_REMOVE, 64'h1);
        send_item(KIND_REMOVE, 64'h1);
        send_item(KIND_AT, 0, 0, 0, 0, 0, 1);
        send_item(KIND_UNKNOWN, 64'h5);
        send_item(KIND_SUMMARY, 0);
        send_item(KIND_CLEAR, 0);
        send_item(KIND_SUMMARY, 0);
    endtask

    // upsert six records into a ring of the given capacity; once it is full the oldest records are overwritten
    task automatic test_overwrite(logic [6:0] cap);
        set_capacity(cap);
        for (int i = 0; i < 6; i++)
            send_item(KIND_UPSERT, 64'h100 + i, 3'(i), 3'(7 - i), i[0], $urandom());
        send_item(KIND_FIND, 64'h100);
        for (int p = 0; p < 4; p++) send_item(KIND_AT, 0, 0, 0, 0, 0, 6'(p));
        send_item(KIND_SUMMARY, 0);
    endtask

    task automatic test_random(int count);
        logic [2:0] kind;
        logic [63:0] k;
        for (int n = 0; n < count; n++) begin
            if (n == count - 40) idling_on = 1'b0;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6: kind = KIND_UPSERT;
                7, 8:                kind = KIND_REMOVE;
                9, 10:               kind = KIND_RESOLVE;
                11, 12, 13:          kind = KIND_FIND;
                14, 15:              kind = KIND_AT;
                16:                  kind = ($urandom_range(0, 3) == 0) ? KIND_CLEAR
                                                                        : KIND_UNKNOWN;
                default:             kind = KIND_SUMMARY;
            endcase
            k = ($urandom_range(0, 30) == 0) ? 64'h0 : pick_key();
            if (kind == KIND_UPSERT && used_keys.size() < 48) used_keys.push_back(k);
            send_item(kind, k, 3'($urandom()), 3'($urandom()), 1'($urandom()), $urandom(),
                      6'((kind == KIND_AT && held != 0 && $urandom_range(0, 3) != 0)
                          ? $urandom_range(0, held - 1) : $urandom()));
        end
    endtask

    initial begin
        capacity = DEPTH; oldest = 0; held = 0;
        serial = 1; received = 0; overwrites = 0; revision = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_overwrite(7'd1);
        test_overwrite(7'd0);      // clamps to one slot
        test_overwrite(7'd3);
        test_overwrite(7'd127);    // clamps to full depth
        set_capacity(7'd5);
        test_random(50);
        idling_on = 1'b1;
        set_capacity(7'd64);
        test_random(50);
        drain();

        $display("covered %0d items, %0d results, capacities 1..64, all operation kinds",
                 items_sent, results_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_results.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
